@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the UART buffering block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ design/uart485_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uart485_pkg
// Event codes, register indexes and queue control types for the UART buffer.
// ---------------------------------------------------------------------------
package uart485_pkg;

   localparam int FUNC_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_PUSH    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RECEIVE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TX_DONE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

   localparam logic REG_RS485_MODE = 1'b0;
   localparam logic REG_FRAME_GAP  = 1'b1;

   localparam logic [7:0] FRAME_GAP_RESET = 8'd3;

   localparam int LEVEL_W = 5;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

@@ design/buffered_uart_rs485_turnaround_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// buffered_uart_rs485_turnaround_core
// Receive and transmit byte queues with shifter hand-off and RS485 turnaround.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one event word (push, pop, line receive, transmit done,
//   tick) with its data byte. rsp_* returns one status word per event: the
//   byte handed to the shifter, the popped byte, push acceptance, overflow,
//   queue levels and the driver / receiver enables.
//   The status word is valid on the cycle after the event is taken.
//   One event per cycle unless the status word stalls; every event is one
//   queue access plus flag updates, and each queue head is prefetched into
//   a register so a pop or transmit hand-off reads it without a memory access.
//   req_ready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds one word and blocks only further events.
//   Reset (synchronous) empties both queues, clears the control flags and
//   rsp_valid, sets rs485_mode to 0, frame_gap to 3; no clearing pass follows.
//   The APB-style port (rs485_mode at 0x0, frame_gap at 0x4) must be written
//   by the user only while no event is in flight; it is not enforced.
// ---------------------------------------------------------------------------
module buffered_uart_rs485_turnaround_core #(
   parameter int RX_DEPTH = 16,
   parameter int TX_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_start,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_accepted,
   output logic        rsp_rx_overflow,
   output logic [4:0]  rsp_rx_level,
   output logic [4:0]  rsp_tx_level,
   output logic        rsp_drive_enable,
   output logic        rsp_receive_enable,
   output logic        rsp_shifter_busy,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int RX_CNT_W = $clog2(RX_DEPTH+1);
   localparam int TX_CNT_W = $clog2(TX_DEPTH+1);
   localparam int LVL_W    = uart485_pkg::LEVEL_W;

   // configuration
   logic       mode_ff;
   logic [7:0] gap_ff;
   logic       csr_write;

   // control state
   logic       overflow_ff, overflow_in;
   logic       busy_ff, busy_in;
   logic       pending_ff, pending_in;
   logic       armed_ff, armed_in;
   logic [7:0] last_rx_ff, last_rx_in;
   logic [7:0] tick_ff, tick_in;

   // queues
   uart485_pkg::q_ctrl_type rx_ctrl, tx_ctrl;
   uart485_pkg::q_stat_type rx_stat, tx_stat;
   logic [7:0]          rx_head, tx_head;
   logic [RX_CNT_W-1:0] rx_count_next;
   logic [TX_CNT_W-1:0] tx_count_next;

   // result register
   logic       rsp_valid_ff;
   logic       tx_start_ff, tx_start_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       rx_valid_ff, rx_valid_in;
   logic [7:0] rx_byte_ff, rx_byte_in;
   logic       accepted_ff, accepted_in;
   logic       overflow_out_ff;
   logic [LVL_W-1:0] rx_level_ff, tx_level_ff;
   logic       drive_ff, drive_in;
   logic       busy_out_ff;

   logic       accept;
   logic       drive_now;
   logic [7:0] since_now, since_tick;
   logic       gap_now, gap_tick;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == uart485_pkg::REG_FRAME_GAP) ? {24'd0, gap_ff}
                                                               : {31'd0, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         gap_ff  <= uart485_pkg::FRAME_GAP_RESET;
      end else if (csr_write) begin
         if (paddr[2] == uart485_pkg::REG_FRAME_GAP) begin
            gap_ff <= pwdata[7:0];
         end else begin
            mode_ff <= pwdata[0];
         end
      end
   end

   // gap test before and after the tick advances
   assign drive_now  = mode_ff && busy_ff;
   assign since_now  = tick_ff - last_rx_ff;
   assign since_tick = tick_ff + 8'd1 - last_rx_ff;
   assign gap_now    = mode_ff && armed_ff && (since_now < gap_ff);
   assign gap_tick   = mode_ff && armed_ff && (since_tick < gap_ff);

   always_comb begin
      overflow_in = overflow_ff;
      busy_in     = busy_ff;
      pending_in  = pending_ff;
      armed_in    = armed_ff;
      last_rx_in  = last_rx_ff;
      tick_in     = tick_ff;
      rx_ctrl     = '0;
      tx_ctrl     = '0;
      tx_start_in = 1'b0;
      tx_byte_in  = 8'd0;
      rx_valid_in = 1'b0;
      rx_byte_in  = 8'd0;
      accepted_in = 1'b0;
      case (req_func)
         uart485_pkg::FUNC_PUSH: begin
            if (!tx_stat.full) begin
               accepted_in = 1'b1;
               if (busy_ff || pending_ff) begin
                  tx_ctrl.push = 1'b1;
               end else if (gap_now) begin
                  // defer the start to a later tick
                  tx_ctrl.push = 1'b1;
                  pending_in   = 1'b1;
               end else begin
                  busy_in     = 1'b1;
                  armed_in    = 1'b0;
                  tx_start_in = 1'b1;
                  tx_byte_in  = req_data_byte;
               end
            end
         end
         uart485_pkg::FUNC_POP: begin
            if (!rx_stat.empty) begin
               rx_valid_in = 1'b1;
               rx_byte_in  = rx_head;
               rx_ctrl.pop = 1'b1;
            end
         end
         uart485_pkg::FUNC_RECEIVE: begin
            if (!drive_now) begin
               rx_ctrl.push = 1'b1;
               if (rx_stat.full) begin
                  overflow_in = 1'b1;
               end
               armed_in   = 1'b1;
               last_rx_in = tick_ff;
            end
         end
         uart485_pkg::FUNC_TX_DONE: begin
            if (busy_ff) begin
               if (!tx_stat.empty) begin
                  tx_start_in = 1'b1;
                  tx_byte_in  = tx_head;
                  tx_ctrl.pop = 1'b1;
               end else begin
                  busy_in = 1'b0;
               end
            end
         end
         uart485_pkg::FUNC_TICK: begin
            tick_in = tick_ff + 8'd1;
            if (pending_ff && !gap_tick) begin
               pending_in = 1'b0;
               if (!tx_stat.empty) begin
                  busy_in     = 1'b1;
                  armed_in    = 1'b0;
                  tx_start_in = 1'b1;
                  tx_byte_in  = tx_head;
                  tx_ctrl.pop = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         rx_ctrl = '0;
         tx_ctrl = '0;
      end
   end

   assign drive_in = mode_ff && busy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         last_rx_ff   <= 8'd0;
         tick_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            overflow_ff  <= overflow_in;
            busy_ff      <= busy_in;
            pending_ff   <= pending_in;
            armed_ff     <= armed_in;
            last_rx_ff   <= last_rx_in;
            tick_ff      <= tick_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         tx_start_ff     <= tx_start_in;
         tx_byte_ff      <= tx_byte_in;
         rx_valid_ff     <= rx_valid_in;
         rx_byte_ff      <= rx_byte_in;
         accepted_ff     <= accepted_in;
         overflow_out_ff <= overflow_in;
         rx_level_ff     <= LVL_W'(rx_count_next);
         tx_level_ff     <= LVL_W'(tx_count_next);
         drive_ff        <= drive_in;
         busy_out_ff     <= busy_in;
      end
   end

   uart485_queue #(
      .DEPTH (RX_DEPTH)
   ) u_rx_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (rx_ctrl),
      .wr_data    (req_data_byte),
      .head       (rx_head),
      .stat       (rx_stat),
      .count_next (rx_count_next)
   );

   uart485_queue #(
      .DEPTH (TX_DEPTH)
   ) u_tx_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tx_ctrl),
      .wr_data    (req_data_byte),
      .head       (tx_head),
      .stat       (tx_stat),
      .count_next (tx_count_next)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_start       = tx_start_ff;
   assign rsp_tx_byte        = tx_byte_ff;
   assign rsp_rx_valid       = rx_valid_ff;
   assign rsp_rx_byte        = rx_byte_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_rx_overflow    = overflow_out_ff;
   assign rsp_rx_level       = rx_level_ff;
   assign rsp_tx_level       = tx_level_ff;
   assign rsp_drive_enable   = drive_ff;
   assign rsp_receive_enable = !drive_ff;
   assign rsp_shifter_busy   = busy_out_ff;

   `ASSERT_NEVER(a_pending_busy, clock, reset, pending_ff && busy_ff,
      "deferred start while shifter busy")
   `ASSERT_PROP(a_pending_queued, clock, reset, pending_ff |-> !tx_stat.empty,
      "deferred start without queued word")
   `ASSERT_PROP(a_start_busy, clock, reset,
      (rsp_valid_ff && tx_start_ff) |-> busy_out_ff,
      "shifter start reported while idle")

endmodule

@@ design/uart485_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// uart485_queue
// Byte ring queue with a prefetched head word; a push into a full queue
// overwrites the oldest word.
// ---------------------------------------------------------------------------
module uart485_queue #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  uart485_pkg::q_ctrl_type       ctrl,
   input  logic [7:0]                    wr_data,
   output logic [7:0]                    head,
   output uart485_pkg::q_stat_type       stat,
   output logic [$clog2(DEPTH+1)-1:0]    count_next
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       head_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   assign full = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = ctrl.push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         if (full) begin
            // drop the oldest word
            rd_ptr_in = wr_ptr_in;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (ctrl.pop) begin
         rd_ptr_in = ptr_inc(rd_ptr_ff);
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage with registered head read; forward a word written at the new head
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (ctrl.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wr_data;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign head       = head_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = full;
   assign count_next = count_in;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(DEPTH),
      "queue count above depth")
   `ASSERT_NEVER(a_pop_empty, clock, reset, ctrl.pop && (count_ff == '0),
      "pop from empty queue")
   `ASSERT_PROP(a_ptr_match, clock, reset,
      ((count_ff == '0) || (count_ff == CNT_W'(DEPTH))) |-> (wr_ptr_ff == rd_ptr_ff),
      "pointers disagree with count")

endmodule
